>>> rtl/core/ppmdb_pkg.sv
package ppmdb_pkg;

  // Width of the parsed dimensions, token accumulator and scan counters
  localparam int DIM_BITS = 16;

  // Command queue between the parser and the pixel writer
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_COLOR  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_ENABLE = 2'd3;
  localparam logic [23:0] KEY_COLOR_RST = 24'h00FF00;

  // Characters the header parser looks for
  localparam logic [7:0] CH_SIX  = 8'h36;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_LF   = 8'h0A;

  typedef enum logic [2:0] {
    PH_MAGIC0,
    PH_MAGIC1,
    PH_SKIP,
    PH_TOK_W,
    PH_TOK_H,
    PH_TOK_M,
    PH_PIXELS,
    PH_HALT
  } phase_t;

  typedef enum logic [1:0] {
    EV_PIXEL   = 2'd0,
    EV_HEADER  = 2'd1,
    EV_BAD_VER = 2'd2
  } kind_t;

  // One command from the parser to the writer
  typedef struct packed {
    kind_t                kind;
    logic [DIM_BITS-1:0]  x;
    logic [DIM_BITS-1:0]  y;
    logic [23:0]          color;
    logic [DIM_BITS-1:0]  w;
    logic [DIM_BITS-1:0]  h;
  } qent_t;

  // Result item as it leaves the block
  typedef struct packed {
    kind_t        kind;
    logic [15:0]  pos_x;
    logic [15:0]  pos_y;
    logic [23:0]  color;
    logic [15:0]  width;
    logic [15:0]  height;
  } res_t;

endpackage

>>> rtl/core/ppm_image_decode_blit.sv
// Channel   Direction  Handshake                Payload
// in_       slave      in_tvalid / in_tready    in_tdata: file_byte; in_tuser: start_of_file
// out_      master     out_tvalid / out_tready  out_tdata: pos_x .. image_height;
//                                               out_tuser: event_kind
// cfg_      write      cfg_we                   cfg_idx, cfg_data
//
// One file byte is taken every cycle while the queue has room; the parser updates its
// state in that cycle and posts at most one command into a four-entry queue. The writer
// drains one command a cycle, unless out_tready holds the output, into a single output
// register. in_tready drops only while the queue is full; a stall on out_tready backs up
// the queue first. Reset (rst_n, synchronous) clears the parser, queue and output valid
// and restores the register reset values.
module ppm_image_decode_blit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,   // [7:0] file_byte
  input  logic                              in_tuser,   // [0] start_of_file
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [87:0]                       out_tdata,  // [15:0] pos_x, [31:16] pos_y,
                                                        // [55:32] color,
                                                        // [71:56] image_width,
                                                        // [87:72] image_height
  output logic [1:0]                        out_tuser,  // [1:0] event_kind
  input  logic                              cfg_we,
  input  logic [ppmdb_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [ppmdb_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import ppmdb_pkg::*;

  logic   accept;
  logic   push;
  qent_t  push_ent;
  logic   pop;
  qent_t  head_ent;
  logic   not_empty;
  logic   full;
  res_t   res;

  assign in_tready = !full;
  assign accept    = in_tvalid && in_tready;

  ppmdb_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .file_byte     (in_tdata),
    .start_of_file (in_tuser),
    .push          (push),
    .push_ent      (push_ent)
  );

  ppmdb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_ent  (push_ent),
    .pop       (pop),
    .head_ent  (head_ent),
    .not_empty (not_empty),
    .full      (full)
  );

  ppmdb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data),
    .head_ent  (head_ent),
    .not_empty (not_empty),
    .pop       (pop),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  assign out_tdata = {res.height, res.width, res.color, res.pos_y, res.pos_x};
  assign out_tuser = res.kind;

endmodule

>>> rtl/core/ppmdb_front.sv
module ppmdb_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [7:0]          file_byte,
  input  logic                start_of_file,
  output logic                push,
  output ppmdb_pkg::qent_t    push_ent
);
  import ppmdb_pkg::*;

  phase_t               phase_r, phase_nxt, phase_c;
  logic                 in_comment_r, in_comment_nxt, in_comment_c;
  logic                 tok_started_r, tok_started_nxt, tok_started_c;
  logic [DIM_BITS-1:0]  accum_r, accum_nxt, accum_c;
  logic [DIM_BITS-1:0]  width_r, width_nxt, width_c;
  logic [DIM_BITS-1:0]  height_r, height_nxt, height_c;
  logic [7:0]           red_r, red_nxt, red_c;
  logic [7:0]           green_r, green_nxt, green_c;
  logic [1:0]           bip_r, bip_nxt, bip_c;
  logic [DIM_BITS-1:0]  col_r, col_nxt, col_c;
  logic [DIM_BITS-1:0]  row_r, row_nxt, row_c;
  logic                 tok_done;
  logic [DIM_BITS-1:0]  col_inc;
  logic                 ev;
  qent_t                ent;

  // Start flag restarts the parser from its reset view
  always_comb begin
    if (start_of_file) begin
      phase_c       = PH_MAGIC0;
      in_comment_c  = 1'b0;
      tok_started_c = 1'b0;
      accum_c       = '0;
      width_c       = '0;
      height_c      = '0;
      red_c         = '0;
      green_c       = '0;
      bip_c         = '0;
      col_c         = '0;
      row_c         = '0;
    end else begin
      phase_c       = phase_r;
      in_comment_c  = in_comment_r;
      tok_started_c = tok_started_r;
      accum_c       = accum_r;
      width_c       = width_r;
      height_c      = height_r;
      red_c         = red_r;
      green_c       = green_r;
      bip_c         = bip_r;
      col_c         = col_r;
      row_c         = row_r;
    end
  end

  assign col_inc = col_c + DIM_BITS'(1);

  // Next state and queue command
  always_comb begin
    phase_nxt       = phase_c;
    in_comment_nxt  = in_comment_c;
    tok_started_nxt = tok_started_c;
    accum_nxt       = accum_c;
    width_nxt       = width_c;
    height_nxt      = height_c;
    red_nxt         = red_c;
    green_nxt       = green_c;
    bip_nxt         = bip_c;
    col_nxt         = col_c;
    row_nxt         = row_c;
    tok_done        = 1'b0;
    ev              = 1'b0;
    ent             = '0;

    // Token reader, used by the three header token phases
    if (phase_c == PH_TOK_W || phase_c == PH_TOK_H || phase_c == PH_TOK_M) begin
      if (in_comment_c) begin
        if (file_byte == CH_LF) begin
          in_comment_nxt = 1'b0;
        end
      end else if (!tok_started_c && file_byte == CH_HASH) begin
        in_comment_nxt = 1'b1;
      end else if (file_byte == CH_SP || file_byte == CH_LF) begin
        tok_done        = 1'b1;
        accum_nxt       = '0;
        tok_started_nxt = 1'b0;
      end else begin
        tok_started_nxt = 1'b1;
        accum_nxt = DIM_BITS'({accum_c, 3'b000}) + DIM_BITS'({accum_c, 1'b0})
                    + DIM_BITS'(file_byte) - DIM_BITS'(CH_ZERO);
      end
    end

    unique case (phase_c)
      PH_MAGIC0: phase_nxt = PH_MAGIC1;
      PH_MAGIC1: begin
        if (file_byte != CH_SIX) begin
          phase_nxt = PH_HALT;
          ev        = 1'b1;
          ent.kind  = EV_BAD_VER;
        end else begin
          phase_nxt = PH_SKIP;
        end
      end
      PH_SKIP: phase_nxt = PH_TOK_W;
      PH_TOK_W: begin
        if (tok_done) begin
          width_nxt = accum_c;
          phase_nxt = PH_TOK_H;
        end
      end
      PH_TOK_H: begin
        if (tok_done) begin
          height_nxt = accum_c;
          phase_nxt  = PH_TOK_M;
        end
      end
      PH_TOK_M: begin
        if (tok_done) begin
          phase_nxt = PH_PIXELS;
          ev        = 1'b1;
          ent.kind  = EV_HEADER;
          ent.w     = width_c;
          ent.h     = height_c;
        end
      end
      PH_PIXELS: begin
        case (bip_c)
          2'd0: begin
            red_nxt = file_byte;
            bip_nxt = 2'd1;
          end
          2'd1: begin
            green_nxt = file_byte;
            bip_nxt   = 2'd2;
          end
          default: begin
            bip_nxt = 2'd0;
            if (width_c != '0 && row_c < height_c) begin
              ev        = 1'b1;
              ent.kind  = EV_PIXEL;
              ent.x     = col_c;
              ent.y     = row_c;
              ent.color = {red_c, green_c, file_byte};
              ent.w     = width_c;
              ent.h     = height_c;
              // Advance the scan position
              if (col_inc >= width_c) begin
                col_nxt = '0;
                row_nxt = row_c + DIM_BITS'(1);
              end else begin
                col_nxt = col_inc;
              end
            end
          end
        endcase
      end
      PH_HALT: phase_nxt = PH_HALT;
      default: phase_nxt = PH_HALT;
    endcase
  end

  assign push     = accept && ev;
  assign push_ent = ent;

  // Parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_MAGIC0;
      in_comment_r  <= 1'b0;
      tok_started_r <= 1'b0;
      accum_r       <= '0;
      width_r       <= '0;
      height_r      <= '0;
      red_r         <= '0;
      green_r       <= '0;
      bip_r         <= '0;
      col_r         <= '0;
      row_r         <= '0;
    end else if (accept) begin
      phase_r       <= phase_nxt;
      in_comment_r  <= in_comment_nxt;
      tok_started_r <= tok_started_nxt;
      accum_r       <= accum_nxt;
      width_r       <= width_nxt;
      height_r      <= height_nxt;
      red_r         <= red_nxt;
      green_r       <= green_nxt;
      bip_r         <= bip_nxt;
      col_r         <= col_nxt;
      row_r         <= row_nxt;
    end
  end

endmodule

>>> rtl/core/ppmdb_queue.sv
module ppmdb_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ppmdb_pkg::qent_t  push_ent,
  input  logic              pop,
  output ppmdb_pkg::qent_t  head_ent,
  output logic              not_empty,
  output logic              full
);
  import ppmdb_pkg::*;

  qent_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  count_r, count_nxt;

  assign not_empty = (count_r != '0);
  assign full      = (count_r == QCNT_W'(QDEPTH));
  assign head_ent  = mem_r[rd_ptr_r];

  // Pointer and fill level update
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_ent;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("command queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("command queue underflow");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QDEPTH))
    else $error("command queue count out of range");

  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0 || full) |-> (wr_ptr_r == rd_ptr_r))
    else $error("command queue pointers disagree with count");

endmodule

>>> rtl/core/ppmdb_back.sv
module ppmdb_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [ppmdb_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [ppmdb_pkg::CFG_DATA_W-1:0] cfg_data,
  input  ppmdb_pkg::qent_t                head_ent,
  input  logic                            not_empty,
  output logic                            pop,
  output logic                            res_valid,
  input  logic                            res_ready,
  output ppmdb_pkg::res_t                 res
);
  import ppmdb_pkg::*;

  logic [15:0]  origin_x_r, origin_y_r;
  logic [23:0]  key_color_r;
  logic         key_enable_r;
  logic         res_valid_r, res_valid_nxt;
  res_t         res_r, res_nxt;
  logic         drop;
  logic         load;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r   <= '0;
      origin_y_r   <= '0;
      key_color_r  <= KEY_COLOR_RST;
      key_enable_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_ORIGIN_X:   origin_x_r   <= cfg_data[15:0];
        CFG_ORIGIN_Y:   origin_y_r   <= cfg_data[15:0];
        CFG_KEY_COLOR:  key_color_r  <= cfg_data[23:0];
        CFG_KEY_ENABLE: key_enable_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Take a command whenever the output register is free or draining
  assign pop  = not_empty && (!res_valid_r || res_ready);
  assign drop = (head_ent.kind == EV_PIXEL) && key_enable_r
                && (head_ent.color == key_color_r);
  assign load = pop && !drop;

  // Format the result item
  always_comb begin
    res_nxt      = '0;
    res_nxt.kind = head_ent.kind;
    case (head_ent.kind)
      EV_PIXEL: begin
        res_nxt.pos_x  = 16'(head_ent.x) + origin_x_r;
        res_nxt.pos_y  = 16'(head_ent.y) + origin_y_r;
        res_nxt.color  = head_ent.color;
        res_nxt.width  = 16'(head_ent.w);
        res_nxt.height = 16'(head_ent.h);
      end
      EV_HEADER: begin
        res_nxt.width  = 16'(head_ent.w);
        res_nxt.height = 16'(head_ent.h);
      end
      default: ;
    endcase
  end

  always_comb begin
    if (load) begin
      res_valid_nxt = 1'b1;
    end else if (res_ready) begin
      res_valid_nxt = 1'b0;
    end else begin
      res_valid_nxt = res_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else begin
      res_valid_r <= res_valid_nxt;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_nxt;
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

  a_no_load_when_held: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid_r && !res_ready) |-> !pop)
    else $error("writer took a command while the result was held");

  a_keyed_pixel_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && drop) |=> !res_valid_r)
    else $error("keyed pixel reached the output");

  a_header_no_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid_r && res_r.kind != EV_PIXEL) |-> (res_r.pos_x == '0
      && res_r.pos_y == '0 && res_r.color == '0))
    else $error("non-pixel result carries a position or color");

  a_valid_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(res_valid_r)) |-> $past(load))
    else $error("result appeared without a command");

endmodule

>>> dv/ppm_image_decode_blit_tb.sv
`timescale 1ns / 1ps

module ppm_image_decode_blit_tb;
  import ppmdb_pkg::*;

  localparam int STALL_LIMIT     = 2000;
  localparam int N_PHASES        = 6;
  localparam int BYTES_PER_PHASE = 260;
  localparam int CHOKE_LEN       = 300;
  localparam int N_DIRECTED      = 25;
  localparam res_t NO_EVENT      = '0;

  typedef enum {RX_OPEN, RX_COIN, RX_SLOW} rx_mode_t;

  // One byte to send, with an optional hand-written expectation
  typedef struct {
    logic [7:0] b;
    logic       sof;
    bit         typed;
    bit         has_res;
    res_t       res;
  } feed_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;
  logic        in_tuser   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [87:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  ppm_image_decode_blit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Decoder copy: register settings
  logic [15:0] org_x, org_y;
  logic [23:0] key_rgb;
  logic        key_on;

  // Decoder copy: parser state
  phase_t      ph;
  bit          in_cmt, tok_live;
  logic [15:0] tok_acc, img_w, img_h, col_i, row_i;
  logic [7:0]  red_b, grn_b;
  logic [1:0]  rgb_slot;

  feed_t feed_q[$];
  res_t  event_q[$];

  int n_bytes, n_files, n_pix, n_hdr, n_bad, n_cfg, errs;
  int quiet;
  int rx_cyc, rx_hold;
  rx_mode_t rx_mode = RX_OPEN;
  res_t want_ev;

  task automatic clear_parser();
    ph       = PH_MAGIC0;
    in_cmt   = 1'b0;
    tok_live = 1'b0;
    tok_acc  = '0;
    img_w    = '0;
    img_h    = '0;
    red_b    = '0;
    grn_b    = '0;
    rgb_slot = '0;
    col_i    = '0;
    row_i    = '0;
  endtask

  // Feed one header character; done when a space or newline ends the token
  task automatic take_token_char(input logic [7:0] b, output bit done, output logic [15:0] v);
    done = 1'b0;
    v = '0;
    if (in_cmt) begin
      if (b == CH_LF) in_cmt = 1'b0;
    end else if (!tok_live && b == CH_HASH) begin
      in_cmt = 1'b1;
    end else if (b == CH_SP || b == CH_LF) begin
      v = tok_acc;
      tok_acc = '0;
      tok_live = 1'b0;
      done = 1'b1;
    end else begin
      // any other byte counts as a digit, no range check
      tok_live = 1'b1;
      tok_acc = 16'(32'(tok_acc) * 10 + 32'(b) - 32'(CH_ZERO));
    end
  endtask

  // Work out the event (if any) caused by one accepted file byte
  task automatic decode_byte(input logic [7:0] b, input logic sof, output bit hit,
                             output res_t r);
    bit          done;
    logic [15:0] v;
    logic [23:0] c;
    hit = 1'b0;
    r = NO_EVENT;
    if (sof) clear_parser();
    case (ph)
      PH_MAGIC0: ph = PH_MAGIC1;
      PH_MAGIC1: begin
        if (b != CH_SIX) begin
          ph = PH_HALT;
          hit = 1'b1;
          r.kind = EV_BAD_VER;
        end else begin
          ph = PH_SKIP;
        end
      end
      PH_SKIP: ph = PH_TOK_W;
      PH_TOK_W: begin
        take_token_char(b, done, v);
        if (done) begin
          img_w = v;
          ph = PH_TOK_H;
        end
      end
      PH_TOK_H: begin
        take_token_char(b, done, v);
        if (done) begin
          img_h = v;
          ph = PH_TOK_M;
        end
      end
      PH_TOK_M: begin
        take_token_char(b, done, v);
        if (done) begin
          ph = PH_PIXELS;
          hit = 1'b1;
          r.kind = EV_HEADER;
          r.width = img_w;
          r.height = img_h;
        end
      end
      PH_PIXELS: begin
        if (rgb_slot == 2'd0) begin
          red_b = b;
          rgb_slot = 2'd1;
        end else if (rgb_slot == 2'd1) begin
          grn_b = b;
          rgb_slot = 2'd2;
        end else begin
          rgb_slot = 2'd0;
          // drop pixels of an empty image or past the last row
          if (img_w != 0 && row_i < img_h) begin
            c = {red_b, grn_b, b};
            r.kind = EV_PIXEL;
            r.pos_x = col_i + org_x;
            r.pos_y = row_i + org_y;
            r.color = c;
            r.width = img_w;
            r.height = img_h;
            col_i = col_i + 16'd1;
            if (col_i >= img_w) begin
              col_i = '0;
              row_i = row_i + 16'd1;
            end
            hit = !(key_on && c == key_rgb);
          end
        end
      end
      default: ;
    endcase
  endtask

  function automatic feed_t pred_row(logic [7:0] b, logic sof);
    feed_t f;
    f = '{b: b, sof: sof, typed: 1'b0, has_res: 1'b0, res: NO_EVENT};
    return f;
  endfunction

  function automatic feed_t known_row(logic [7:0] b, logic sof, bit has, res_t res);
    feed_t f;
    f = '{b: b, sof: sof, typed: 1'b1, has_res: has, res: res};
    return f;
  endfunction

  task automatic put(input logic [7:0] b, input logic sof = 1'b0);
    feed_q.push_back(pred_row(b, sof));
  endtask

  // Emit one header token, maybe behind a comment; val < 0 gives an empty token
  task automatic put_token(input int val, input bit junk);
    string      s;
    logic [7:0] b;
    if ($urandom_range(0, 4) == 0) begin
      put(CH_HASH);
      repeat ($urandom_range(0, 4)) begin
        do b = 8'($urandom); while (b == CH_LF);
        put(b);
      end
      put(CH_LF);
    end
    if (junk) begin
      repeat ($urandom_range(1, 3)) begin
        do b = 8'($urandom); while (b == CH_SP || b == CH_LF || b == CH_HASH);
        put(b);
      end
    end else if (val >= 0) begin
      if ($urandom_range(0, 5) == 0) put(CH_ZERO);
      s = $sformatf("%0d", val);
      for (int i = 0; i < s.len(); i++) put(s[i]);
    end
    put($urandom_range(0, 1) ? CH_SP : CH_LF);
  endtask

  // Append one file: mostly well formed, some bad versions, noise and broken headers
  task automatic build_file();
    int          kind, w, h, mx, npx;
    logic [7:0]  b;
    logic [23:0] c;
    kind = $urandom_range(0, 99);
    put(8'($urandom), 1'b1);
    if (kind < 8) begin
      do b = 8'($urandom); while (b == CH_SIX);
      put(b);
      repeat ($urandom_range(0, 6)) put(8'($urandom));
    end else if (kind < 12) begin
      repeat ($urandom_range(1, 20)) put(8'($urandom));
    end else begin
      put(CH_SIX);
      put(8'($urandom));
      case ($urandom_range(0, 19))
        0:       w = 0;
        1:       w = 65535;
        2:       w = 70000;
        3:       w = $urandom_range(7, 40);
        default: w = $urandom_range(1, 6);
      endcase
      h = ($urandom_range(0, 12) == 0) ? 0 : $urandom_range(1, 5);
      case ($urandom_range(0, 5))
        0:       mx = -1;
        1:       mx = $urandom_range(0, 99999);
        default: mx = 255;
      endcase
      if (kind < 20) begin
        // junk inside the width, or a file cut short after it
        put_token(w, kind < 16);
        if (kind < 16) begin
          put_token(h, 1'b0);
          put_token(mx, 1'b0);
        end
        repeat ($urandom_range(0, 30)) put(8'($urandom));
      end else begin
        put_token(w, 1'b0);
        put_token(h, 1'b0);
        put_token(mx, 1'b0);
        npx = (w * h > 24) ? 24 : w * h;
        if (npx == 0) npx = $urandom_range(0, 3);
        repeat (npx) begin
          case ($urandom_range(0, 9))
            0, 1, 2: c = key_rgb;
            3:       c = 24'h000000;
            4:       c = 24'hFFFFFF;
            default: c = 24'($urandom);
          endcase
          put(c[23:16]);
          put(c[15:8]);
          put(c[7:0]);
        end
        if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 7)) put(8'($urandom));
      end
    end
  endtask

  // Write all four registers back to back while the block is idle
  task automatic set_regs(input logic [15:0] ox, input logic [15:0] oy,
                          input logic [23:0] kc, input logic ke);
    cfg_we <= 1'b1;
    cfg_idx <= CFG_ORIGIN_X;
    cfg_data <= {8'd0, ox};
    @(posedge clk);
    cfg_idx <= CFG_ORIGIN_Y;
    cfg_data <= {8'd0, oy};
    @(posedge clk);
    cfg_idx <= CFG_KEY_COLOR;
    cfg_data <= kc;
    @(posedge clk);
    cfg_idx <= CFG_KEY_ENABLE;
    cfg_data <= {23'd0, ke};
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_data <= 24'($urandom);
    org_x = ox;
    org_y = oy;
    key_rgb = kc;
    key_on = ke;
    n_cfg++;
  endtask

  // Send the pending bytes in bursts with random gaps; predict on each transfer
  task automatic send_bytes();
    feed_t f;
    int    burst, gap;
    bit    hit;
    res_t  r;
    while (feed_q.size() != 0) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && feed_q.size() != 0) begin
        f = feed_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= f.b;
        in_tuser <= f.sof;
        do @(posedge clk); while (!in_tready);
        decode_byte(f.b, f.sof, hit, r);
        if (f.typed) begin
          hit = f.has_res;
          r = f.res;
        end
        if (hit) event_q.push_back(r);
        n_bytes++;
        if (f.sof) n_files++;
        burst--;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0 || feed_q.size() == 0) begin
        in_tvalid <= 1'b0;
        in_tdata <= 8'($urandom);
        in_tuser <= 1'($urandom);
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Wait for every expected event, then let the pipeline go quiet
  task automatic settle();
    while (event_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [23:0] want,
                             input logic [23:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      errs++;
    end
  endtask

  // Main sequence: reset, directed rows, then random files under several settings
  initial begin
    feed_t dir_rows[N_DIRECTED];
    dir_rows = '{
      known_row("P", 1'b1, 1'b0, NO_EVENT),
      known_row("5", 1'b0, 1'b1, '{EV_BAD_VER, 16'd0, 16'd0, 24'd0, 16'd0, 16'd0}),
      known_row("X", 1'b0, 1'b0, NO_EVENT),
      known_row("P", 1'b1, 1'b0, NO_EVENT),
      known_row(CH_SIX, 1'b0, 1'b0, NO_EVENT),
      pred_row(CH_LF, 1'b0),
      pred_row(CH_HASH, 1'b0),
      pred_row("z", 1'b0),
      pred_row(CH_LF, 1'b0),
      pred_row("2", 1'b0),
      pred_row(CH_SP, 1'b0),
      pred_row("1", 1'b0),
      pred_row(CH_LF, 1'b0),
      pred_row("9", 1'b0),
      pred_row(CH_HASH, 1'b0),
      known_row(CH_SP, 1'b0, 1'b1, '{EV_HEADER, 16'd0, 16'd0, 24'd0, 16'd2, 16'd1}),
      pred_row(8'h00, 1'b0),
      pred_row(8'hFF, 1'b0),
      known_row(8'h00, 1'b0, 1'b0, NO_EVENT),
      pred_row(8'hFF, 1'b0),
      pred_row(8'hFF, 1'b0),
      known_row(8'hFF, 1'b0, 1'b1,
                '{EV_PIXEL, 16'd1, 16'd0, 24'hFFFFFF, 16'd2, 16'd1}),
      pred_row(8'h12, 1'b0),
      pred_row(8'h34, 1'b0),
      known_row(8'h56, 1'b0, 1'b0, NO_EVENT)
    };
    org_x = '0;
    org_y = '0;
    key_rgb = KEY_COLOR_RST;
    key_on = 1'b1;
    clear_parser();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0: ;
        1: set_regs(16'hFFFF, 16'hFFFF, 24'h000000, 1'b1);
        2: set_regs(16'($urandom), 16'($urandom), 24'hFFFFFF, 1'b0);
        3: set_regs(16'h0000, 16'hFFFF, 24'($urandom), 1'b1);
        4: set_regs(16'hFFF8, 16'h0003, KEY_COLOR_RST, 1'b0);
        default: set_regs(16'($urandom), 16'($urandom), 24'($urandom), 1'b1);
      endcase
      if (p == 0) begin
        for (int i = 0; i < N_DIRECTED; i++) feed_q.push_back(dir_rows[i]);
      end
      while (feed_q.size() < BYTES_PER_PHASE) build_file();
      send_bytes();
      settle();
    end

    $display("ppm_image_decode_blit_tb: %0d bytes in %0d files over %0d register settings",
             n_bytes, n_files, n_cfg + 1);
    $display("ppm_image_decode_blit_tb: %0d pixel writes, %0d headers, %0d version errors",
             n_pix, n_hdr, n_bad);
    if (errs == 0) begin
      $display("ppm_image_decode_blit_tb: done, clean");
    end else begin
      $display("ppm_image_decode_blit_tb: done, errors");
    end
    $finish;
  end

  // Receiver: stall pattern drawn at random from open, coin-flip and slow modes, plus long hold-offs
  always @(posedge clk) begin
    rx_cyc++;
    if (rx_cyc % 50 == 0) rx_mode = rx_mode_t'($urandom_range(0, 2));
    if (rx_cyc == 900 || rx_cyc == 2000 || rx_cyc == 3100) rx_hold = CHOKE_LEN;
    if (rx_hold > 0) begin
      rx_hold--;
      out_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_OPEN: out_tready <= 1'b1;
        RX_COIN: out_tready <= 1'($urandom);
        default: out_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Compare each result transfer with the oldest expected event
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (event_q.size() == 0) begin
        $error("unexpected result: kind %0d, data %h", out_tuser, out_tdata);
        errs++;
      end else begin
        want_ev = event_q.pop_front();
        check_field("event_kind", 24'(want_ev.kind), 24'(out_tuser));
        check_field("pos_x", 24'(want_ev.pos_x), 24'(out_tdata[15:0]));
        check_field("pos_y", 24'(want_ev.pos_y), 24'(out_tdata[31:16]));
        check_field("color", want_ev.color, out_tdata[55:32]);
        check_field("image_width", 24'(want_ev.width), 24'(out_tdata[71:56]));
        check_field("image_height", 24'(want_ev.height), 24'(out_tdata[87:72]));
        case (want_ev.kind)
          EV_PIXEL:  n_pix++;
          EV_HEADER: n_hdr++;
          default:   n_bad++;
        endcase
      end
    end
  end

  // Watchdog: end the run when no transfer happens for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet == STALL_LIMIT) begin
      $display("no transfer for %0d cycles, %0d events still expected",
               STALL_LIMIT, event_q.size());
      $display("ppm_image_decode_blit_tb: done, errors");
      $finish;
    end
  end

endmodule

>>> files.f
rtl/core/ppmdb_pkg.sv
rtl/core/ppmdb_front.sv
rtl/core/ppmdb_queue.sv
rtl/core/ppmdb_back.sv
rtl/core/ppm_image_decode_blit.sv
dv/ppm_image_decode_blit_tb.sv
